>>> hdl/pppc_pkg.sv
// ----------------------------------------------------------------------------
// pppc_pkg
// shared types and constants for the pulse period and phase capture unit
// ----------------------------------------------------------------------------
package pppc_pkg;

   // timestamp width of the capture counter
   localparam int STAMP_BITS = 48;
   localparam int VALUE_BITS = 16;

   // request codes
   localparam logic [1:0] REQ_GRID    = 2'd0;
   localparam logic [1:0] REQ_SENSOR  = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_GRID_PERIOD     = 2'd0;
   localparam logic [1:0] KIND_SENSOR_PERIOD   = 2'd1;
   localparam logic [1:0] KIND_DELAY_MONITOR   = 2'd2;
   localparam logic [1:0] KIND_DELAY_OPERATION = 2'd3;

   // register map
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WINDOW     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SENSOR_WINDOW   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FREQ_MONITOR_EN = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIFF_MONITOR_EN = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OPERATION_EN    = 3'd4;

   // result queue sizing
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = 2;
   localparam int QUEUE_COUNT_BITS = 3;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [STAMP_BITS-1:0] stamp_us;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]            result_kind;
      logic [VALUE_BITS-1:0] result_value;
      logic                  last_of_item;
   } rsp_payload_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] grid_window;
      logic [VALUE_BITS-1:0] sensor_window;
      logic                  freq_monitor_en;
      logic                  diff_monitor_en;
      logic                  operation_en;
   } cfg_type;

   // results produced by one transaction, in order: first, then second
   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type first;
      rsp_payload_type second;
   } push_type;

endpackage

>>> hdl/pulse_period_and_phase_capture_unit.sv
// ----------------------------------------------------------------------------
// pulse_period_and_phase_capture_unit
// period and sensor-to-grid delay capture from timestamped pin edges
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  req_     in         req_valid / req_stall  req_payload_type (event code, stamp)
//  rsp_     out        rsp_valid / rsp_stall  rsp_payload_type (kind, value, last)
//  csr_     in         csr_write_en           csr_index, csr_wdata
//
//  one request transaction is taken every cycle while req_stall is low; the
//  work for it is a single pass of 16-bit subtracts and compares between the
//  input register and the result queue, which holds the results for rsp_
//  a grid edge may give two results; the four-entry result queue drains one
//  per cycle while rsp_stall is low, so a run of such edges can raise req_stall
//  req_stall rises only while the queue lacks room for a pair of results
//  reset is synchronous and clears the registers, tracking flags and queue
//
module pulse_period_and_phase_capture_unit
   import pppc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,
   // configuration writes
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type  cfg;
   push_type push;
   logic     queue_space;

   // window and enable registers
   pppc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // input register plus the per-pin tracking state
   pppc_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_space (queue_space),
      .push        (push)
   );

   // results wait here so a stalled consumer does not hold up requests
   pppc_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .queue_space (queue_space),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> hdl/pppc_csr.sv
// ----------------------------------------------------------------------------
// pppc_csr
// configuration registers written through the plain write port
// ----------------------------------------------------------------------------
module pppc_csr
   import pppc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_GRID_WINDOW:     cfg_in.grid_window     = csr_wdata[VALUE_BITS-1:0];
            CSR_SENSOR_WINDOW:   cfg_in.sensor_window   = csr_wdata[VALUE_BITS-1:0];
            CSR_FREQ_MONITOR_EN: cfg_in.freq_monitor_en = csr_wdata[0];
            CSR_DIFF_MONITOR_EN: cfg_in.diff_monitor_en = csr_wdata[0];
            CSR_OPERATION_EN:    cfg_in.operation_en    = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/pppc_tracker.sv
// ----------------------------------------------------------------------------
// pppc_tracker
// input register, edge tracking state and result generation
// ----------------------------------------------------------------------------
module pppc_tracker
   import pppc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            queue_space,
   output push_type        push
);

   // input register
   logic            hold_valid_ff, hold_valid_in;
   req_payload_type hold_ff, hold_in;

   // tracking state; only the low 16 stamp bits ever reach a result
   logic                  sensor_started_ff, sensor_started_in;
   logic                  grid_started_ff, grid_started_in;
   logic                  phase_armed_ff, phase_armed_in;
   logic [VALUE_BITS-1:0] sensor_last_ff, sensor_last_in;
   logic [VALUE_BITS-1:0] grid_last_ff, grid_last_in;
   logic [VALUE_BITS-1:0] phase_ref_ff, phase_ref_in;

   logic                  accept;
   logic                  fire;
   logic [VALUE_BITS-1:0] now;
   logic [VALUE_BITS-1:0] sensor_gap;
   logic [VALUE_BITS-1:0] grid_gap;
   logic [VALUE_BITS-1:0] delay;
   logic                  phase_on;
   logic                  emit_period;
   logic                  emit_delay;
   rsp_payload_type       period_rsp;
   rsp_payload_type       delay_rsp;

   assign fire      = hold_valid_ff & queue_space;
   assign req_stall = hold_valid_ff & ~queue_space;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_in       = req_payload;
      end else if (fire) begin
         hold_valid_in = 1'b0;
      end
   end

   assign now        = hold_ff.stamp_us[VALUE_BITS-1:0];
   assign sensor_gap = now - sensor_last_ff;
   assign grid_gap   = now - grid_last_ff;
   assign delay      = now - phase_ref_ff;
   assign phase_on   = cfg.diff_monitor_en | cfg.operation_en;

   always_comb begin
      sensor_started_in = sensor_started_ff;
      grid_started_in   = grid_started_ff;
      phase_armed_in    = phase_armed_ff;
      sensor_last_in    = sensor_last_ff;
      grid_last_in      = grid_last_ff;
      phase_ref_in      = phase_ref_ff;
      emit_period       = 1'b0;
      emit_delay        = 1'b0;
      period_rsp        = '0;
      delay_rsp         = '0;

      if (fire) begin
         case (hold_ff.req_type)
            REQ_RESTART: begin
               sensor_started_in = 1'b0;
               grid_started_in   = 1'b0;
               sensor_last_in    = '0;
               grid_last_in      = '0;
               phase_armed_in    = 1'b0;
            end
            REQ_SENSOR: begin
               if (!sensor_started_ff) begin
                  sensor_last_in    = now;
                  sensor_started_in = 1'b1;
               end else if (sensor_gap > cfg.sensor_window) begin
                  sensor_last_in          = now;
                  emit_period             = cfg.freq_monitor_en;
                  period_rsp.result_kind  = KIND_SENSOR_PERIOD;
                  period_rsp.result_value = sensor_gap;
                  if (!phase_armed_ff && phase_on) begin
                     phase_ref_in   = now;
                     phase_armed_in = 1'b1;
                  end
               end
            end
            REQ_GRID: begin
               if (sensor_started_ff) begin
                  if (!grid_started_ff) begin
                     grid_last_in    = now;
                     grid_started_in = 1'b1;
                  end else if (grid_gap > cfg.grid_window) begin
                     grid_last_in            = now;
                     emit_period             = cfg.freq_monitor_en;
                     period_rsp.result_kind  = KIND_GRID_PERIOD;
                     period_rsp.result_value = grid_gap;
                     if (phase_armed_ff && phase_on) begin
                        emit_delay             = 1'b1;
                        delay_rsp.result_kind  = cfg.operation_en ? KIND_DELAY_OPERATION
                                                                  : KIND_DELAY_MONITOR;
                        delay_rsp.result_value = delay;
                        phase_armed_in         = 1'b0;
                     end
                  end
               end
            end
            default: begin
               // unused code: no effect
            end
         endcase
      end
   end

   // order the results: period before delay, last flag on the final one
   always_comb begin
      push = '0;
      if (emit_period && emit_delay) begin
         push.count  = 2'd2;
         push.first  = period_rsp;
         push.second = delay_rsp;
         push.second.last_of_item = 1'b1;
      end else if (emit_period) begin
         push.count  = 2'd1;
         push.first  = period_rsp;
         push.first.last_of_item = 1'b1;
      end else if (emit_delay) begin
         push.count  = 2'd1;
         push.first  = delay_rsp;
         push.first.last_of_item = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff     <= 1'b0;
         sensor_started_ff <= 1'b0;
         grid_started_ff   <= 1'b0;
         phase_armed_ff    <= 1'b0;
         sensor_last_ff    <= '0;
         grid_last_ff      <= '0;
         phase_ref_ff      <= '0;
      end else begin
         hold_valid_ff     <= hold_valid_in;
         sensor_started_ff <= sensor_started_in;
         grid_started_ff   <= grid_started_in;
         phase_armed_ff    <= phase_armed_in;
         sensor_last_ff    <= sensor_last_in;
         grid_last_ff      <= grid_last_in;
         phase_ref_ff      <= phase_ref_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

>>> hdl/pppc_queue.sv
// ----------------------------------------------------------------------------
// pppc_queue
// small result queue taking up to two results a cycle, giving one while rsp_stall is low
// ----------------------------------------------------------------------------
module pppc_queue
   import pppc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  push_type        push,
   output logic            queue_space,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   rsp_payload_type entry_ff [QUEUE_DEPTH];

   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic [QUEUE_PTR_BITS-1:0]   wr_next;
   logic                        pop;

   // room for a full pair of results
   assign queue_space = count_ff <= QUEUE_COUNT_BITS'(QUEUE_DEPTH - 2);
   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid & ~rsp_stall;
   assign wr_next     = wr_ptr_ff + QUEUE_PTR_BITS'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
      count_in  = count_ff + QUEUE_COUNT_BITS'(push.count) - QUEUE_COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking regression for the pulse period and phase capture unit
// ----------------------------------------------------------------------------
//
//  edge and restart events go in on the req_ channel
//  a behavioural copy of the capture logic follows each accepted transaction
//  and queues the results it expects
//  every result taken from rsp_ is checked field by field against the oldest
//  queued result
//  named tests run in turn: directed edge cases, a back-pressure burst, then
//  random traffic under a range of register settings
//  both sides idle at random; a watchdog ends the run if nothing moves
//
module tb_top;
   import pppc_pkg::*;

   // request code with no meaning, must be ignored by the block
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // wait after the last owed result, so this also covers events that give no result
   localparam int SETTLE_CYCLES = 6;
   // cycles without any transaction before the run is declared hung
   localparam int STALL_LIMIT   = 2000;
   // long receiver hold-off, well beyond what the four-entry result queue can absorb
   localparam int HOLD_CYCLES   = 64;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_payload_type           req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_payload_type           rsp_payload;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // register settings as the block should currently hold them
   cfg_type                   shadow_cfg = '0;

   // edge tracking state of the capture logic
   logic                      sensor_started = 1'b0;
   logic                      grid_started = 1'b0;
   logic [STAMP_BITS-1:0]     sensor_last_edge = '0;
   logic [STAMP_BITS-1:0]     grid_last_edge = '0;
   logic [STAMP_BITS-1:0]     phase_reference = '0;
   logic                      phase_armed = 1'b0;

   // results still owed by the block, oldest first
   rsp_payload_type           expected_results[$];
   int                        error_count = 0;

   // idling control shared between the sequencer, sender and receiver
   bit                        quiet_mode = 1'b0;
   int                        rsp_hold_request = 0;
   logic [STAMP_BITS-1:0]     stamp_now = '0;

   pulse_period_and_phase_capture_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // capture prediction
   // -------------------------------------------------------------------------

   function automatic rsp_payload_type result_of(input logic [1:0] kind,
                                                 input logic [VALUE_BITS-1:0] value);
      rsp_payload_type r;
      r = '0;
      r.result_kind  = kind;
      r.result_value = value;
      return r;
   endfunction

   // follows one accepted event and queues the results it should produce
   task automatic predict_capture(input req_payload_type ev);
      rsp_payload_type       found[2];
      int                    n;
      logic [VALUE_BITS-1:0] period;
      logic [VALUE_BITS-1:0] delay;
      logic                  phase_on;
      n = 0;
      phase_on = shadow_cfg.diff_monitor_en || shadow_cfg.operation_en;
      case (ev.req_type)
         REQ_RESTART: begin
            // reference time survives, it is dead while disarmed
            sensor_started   = 1'b0;
            grid_started     = 1'b0;
            sensor_last_edge = '0;
            grid_last_edge   = '0;
            phase_armed      = 1'b0;
         end
         REQ_SENSOR: begin
            if (!sensor_started) begin
               sensor_last_edge = ev.stamp_us;
               sensor_started   = 1'b1;
            end else begin
               // low 16 bits of the wrapped difference
               period = ev.stamp_us[VALUE_BITS-1:0] - sensor_last_edge[VALUE_BITS-1:0];
               if (period > shadow_cfg.sensor_window) begin
                  sensor_last_edge = ev.stamp_us;
                  if (shadow_cfg.freq_monitor_en) begin
                     found[n] = result_of(KIND_SENSOR_PERIOD, period);
                     n++;
                  end
                  // an armed reference is kept, not moved
                  if (!phase_armed && phase_on) begin
                     phase_reference = ev.stamp_us;
                     phase_armed     = 1'b1;
                  end
               end
            end
         end
         REQ_GRID: begin
            // grid edges count only once the sensor side has started
            if (sensor_started) begin
               if (!grid_started) begin
                  grid_last_edge = ev.stamp_us;
                  grid_started   = 1'b1;
               end else begin
                  period = ev.stamp_us[VALUE_BITS-1:0] - grid_last_edge[VALUE_BITS-1:0];
                  if (period > shadow_cfg.grid_window) begin
                     grid_last_edge = ev.stamp_us;
                     if (shadow_cfg.freq_monitor_en) begin
                        found[n] = result_of(KIND_GRID_PERIOD, period);
                        n++;
                     end
                     if (phase_armed && phase_on) begin
                        delay = ev.stamp_us[VALUE_BITS-1:0] - phase_reference[VALUE_BITS-1:0];
                        found[n] = result_of(shadow_cfg.operation_en ? KIND_DELAY_OPERATION
                                                                     : KIND_DELAY_MONITOR,
                                             delay);
                        n++;
                        phase_armed = 1'b0;
                     end
                  end
               end
            end
         end
         default: begin
            // unused code, no effect
         end
      endcase
      if (n > 0) found[n-1].last_of_item = 1'b1;
      for (int i = 0; i < n; i++) expected_results.push_back(found[i]);
   endtask

   // -------------------------------------------------------------------------
   // prediction on accepted requests, comparison on accepted results
   // -------------------------------------------------------------------------

   always @(posedge clock) begin : score
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && !req_stall) predict_capture(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result with nothing expected: kind %0d value %0d last %0d",
                      rsp_payload.result_kind, rsp_payload.result_value,
                      rsp_payload.last_of_item);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.result_kind !== want.result_kind) begin
                  $error("result_kind: expected %0d, actual %0d",
                         want.result_kind, rsp_payload.result_kind);
                  error_count++;
               end
               if (rsp_payload.result_value !== want.result_value) begin
                  $error("result_value: expected %0d, actual %0d",
                         want.result_value, rsp_payload.result_value);
                  error_count++;
               end
               if (rsp_payload.last_of_item !== want.last_of_item) begin
                  $error("last_of_item: expected %0d, actual %0d",
                         want.last_of_item, rsp_payload.last_of_item);
                  error_count++;
               end
            end
         end
      end
   end

   // hang detection: any transaction or register write restarts the count
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("pulse_period_and_phase_capture_unit regression: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // result receiver: random stall before each transaction, or a long hold-off
   // -------------------------------------------------------------------------

   initial begin : receiver
      int hold;
      forever begin
         if (rsp_hold_request > 0) begin
            hold = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (quiet_mode) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 9);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && !reset));
      end
   end

   // -------------------------------------------------------------------------
   // shared stimulus tasks
   // -------------------------------------------------------------------------

   // offers one event, after a random gap unless in quiet mode, and returns at the edge it is taken
   task automatic send_event(input logic [1:0] code, input logic [STAMP_BITS-1:0] stamp);
      int              gap;
      req_payload_type ev;
      gap = quiet_mode ? 0 : $urandom_range(0, 9);
      ev.req_type = code;
      ev.stamp_us = stamp;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= ev;
      do @(posedge clock); while (req_stall);
   endtask

   // sender goes quiet until every owed result is in, then lets the pipe settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      case (index)
         CSR_GRID_WINDOW:     shadow_cfg.grid_window     = value;
         CSR_SENSOR_WINDOW:   shadow_cfg.sensor_window   = value;
         CSR_FREQ_MONITOR_EN: shadow_cfg.freq_monitor_en = value[0];
         CSR_DIFF_MONITOR_EN: shadow_cfg.diff_monitor_en = value[0];
         CSR_OPERATION_EN:    shadow_cfg.operation_en    = value[0];
         default: begin
         end
      endcase
   endtask

   // writes all five registers; flag registers get random upper bits
   task automatic apply_settings(input logic [VALUE_BITS-1:0] gw, input logic [VALUE_BITS-1:0] sw,
                                 input logic fm, input logic dm, input logic op);
      logic [CSR_DATA_BITS-1:0] noise;
      write_register(CSR_GRID_WINDOW, gw);
      write_register(CSR_SENSOR_WINDOW, sw);
      noise = CSR_DATA_BITS'($urandom);
      write_register(CSR_FREQ_MONITOR_EN, {noise[CSR_DATA_BITS-1:1], fm});
      noise = CSR_DATA_BITS'($urandom);
      write_register(CSR_DIFF_MONITOR_EN, {noise[CSR_DATA_BITS-1:1], dm});
      noise = CSR_DATA_BITS'($urandom);
      write_register(CSR_OPERATION_EN, {noise[CSR_DATA_BITS-1:1], op});
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [VALUE_BITS-1:0] pick_window();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2, 3:    return VALUE_BITS'($urandom_range(0, 300));
         default: return VALUE_BITS'($urandom_range(0, 65535));
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------

   // registers still at reset: everything is tracked but nothing is reported
   task automatic test_reset_defaults();
      send_event(REQ_GRID, 48'd100);
      send_event(REQ_SENSOR, 48'd200);
      send_event(REQ_SENSOR, 48'd900);
      drain_results();
   endtask

   // start-up rules, window edge, arming, wrap of the stamp, restart, unused code
   task automatic test_edge_cases();
      logic [STAMP_BITS-1:0] base;
      base = 48'hFFFF_FFFF_FF00;
      apply_settings(16'd5, 16'd10, 1'b1, 1'b1, 1'b0);
      send_event(REQ_GRID, base);                       // ignored, sensor not started
      send_event(REQ_SENSOR, base + 10);                // first sensor edge
      send_event(REQ_GRID, base + 20);                  // first grid edge
      send_event(REQ_SENSOR, base + 20);                // period equals window, rejected
      send_event(REQ_SENSOR, base + 21);                // accepted, arms reference
      send_event(REQ_SENSOR, base + 40);                // already armed, reference kept
      send_event(REQ_GRID, base + 25);                  // grid period equals window
      send_event(REQ_GRID, base + 300);                 // stamp wraps: period then delay
      send_event(REQ_GRID, base + 400);                 // disarmed: period only
      send_event(REQ_UNUSED, '1);
      send_event(REQ_RESTART, '0);
      send_event(REQ_GRID, '0);                         // ignored again after restart
      send_event(REQ_SENSOR, '1);
      send_event(REQ_SENSOR, 48'h0000_0001_0000);       // low 16 bits of period are 1
      send_event(REQ_SENSOR, 48'h0000_0000_8000);       // wrapped period above window
      drain_results();
   endtask

   // operation channel wins over the monitor channel, zero windows
   task automatic test_operation_precedence();
      apply_settings(16'd0, 16'd0, 1'b0, 1'b1, 1'b1);
      send_event(REQ_RESTART, 48'd7);
      send_event(REQ_SENSOR, 48'd1000);
      send_event(REQ_GRID, 48'd1000);
      send_event(REQ_SENSOR, 48'd1000);                 // zero period, not above zero
      send_event(REQ_SENSOR, 48'd1001);
      send_event(REQ_GRID, 48'd1001 + 48'h1_0005);      // delay truncated to 16 bits
      drain_results();
   endtask

   // full-scale windows: no period can exceed them
   task automatic test_window_extremes();
      apply_settings('1, '1, 1'b1, 1'b0, 1'b0);
      send_event(REQ_RESTART, '1);
      send_event(REQ_SENSOR, 48'd0);
      send_event(REQ_SENSOR, 48'd70000);
      send_event(REQ_GRID, 48'd70100);
      drain_results();
   endtask

   // receiver holds off for a long stretch while edges keep coming
   task automatic test_backpressure();
      apply_settings(16'd0, 16'd0, 1'b1, 1'b0, 1'b1);
      quiet_mode = 1'b1;
      stamp_now = STAMP_BITS'({$urandom, $urandom});
      send_event(REQ_RESTART, stamp_now);
      rsp_hold_request = HOLD_CYCLES;
      for (int i = 0; i < 30; i++) begin
         stamp_now = stamp_now + STAMP_BITS'($urandom_range(1, 400));
         send_event((i % 2) ? REQ_GRID : REQ_SENSOR, stamp_now);
      end
      drain_results();
      quiet_mode = 1'b0;
   endtask

   // mostly well-formed edge trains under changing settings, with some noise
   task automatic test_random_traffic();
      int                    choice;
      logic [STAMP_BITS-1:0] stride;
      logic [1:0]            code;
      for (int phase = 0; phase < 8; phase++) begin
         quiet_mode = (phase % 3 == 2);
         if (phase == 0)
            apply_settings('0, '0, 1'b1, 1'b1, 1'b1);
         else if (phase == 7)
            apply_settings('1, '0, 1'b1, 1'b1, 1'b0);
         else
            apply_settings(pick_window(), pick_window(), $urandom_range(0, 3) != 0,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         stamp_now = STAMP_BITS'({$urandom, $urandom});
         for (int i = 0; i < 100; i++) begin
            case ($urandom_range(0, 9))
               0, 1:    stride = STAMP_BITS'($urandom_range(0, 50));
               2, 3, 4: stride = STAMP_BITS'($urandom_range(0, 1000));
               5, 6:    stride = STAMP_BITS'($urandom_range(0, 65535));
               7, 8:    stride = STAMP_BITS'($urandom_range(65536, 200000));
               default: stride = STAMP_BITS'({$urandom, $urandom});
            endcase
            stamp_now = stamp_now + stride;
            choice = $urandom_range(0, 99);
            if (choice < 3) begin
               send_event(REQ_RESTART, stamp_now);
            end else if (choice < 5) begin
               send_event(REQ_UNUSED, stamp_now);
            end else if (choice < 8) begin
               // stray transaction with an arbitrary stamp
               code = 2'($urandom_range(0, 3));
               send_event(code, STAMP_BITS'({$urandom, $urandom}));
            end else if (choice < 52) begin
               send_event(REQ_GRID, stamp_now);
            end else begin
               send_event(REQ_SENSOR, stamp_now);
            end
            if ($urandom_range(0, 59) == 0) drain_results();
         end
         drain_results();
      end
      quiet_mode = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // sequencer
   // -------------------------------------------------------------------------

   initial begin : sequencer
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_edge_cases();
      test_operation_precedence();
      test_window_extremes();
      test_backpressure();
      test_random_traffic();
      drain_results();
      if (error_count == 0 && expected_results.size() == 0)
         $display("pulse_period_and_phase_capture_unit regression: pass");
      else
         $display("pulse_period_and_phase_capture_unit regression: fail");
      $finish;
   end

endmodule
